### rtl/abpr_pkg.sv
// types, constants and packet layout for the alternating-bit packet receiver
// no dependencies
package abpr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned INDEX_W  = 16;
    localparam int unsigned COUNT_W  = 17;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 48;

    localparam int unsigned TYPE_BIT = 1;
    localparam int unsigned SEQ_BIT  = 0;

    localparam logic [INDEX_W-1:0] RESET_LENGTH = 16'd50;
    localparam logic [COUNT_W-1:0] COUNT_STEP   = 17'd3;

    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_META    = 2'd1,
        KIND_DATA    = 2'd2
    } packet_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] check_low;
        logic [BYTE_W-1:0] check_high;
        logic [BYTE_W-1:0] payload_c;
        logic [BYTE_W-1:0] payload_b;
        logic [BYTE_W-1:0] payload_a;
        logic [BYTE_W-1:0] control_byte;
    } packet_t;

    typedef struct packed {
        packet_kind_t       packet_kind;
        logic               accepted;
        logic [INDEX_W-1:0] write_index;
        logic [BYTE_W-1:0]  out_a;
        logic [BYTE_W-1:0]  out_b;
        logic [BYTE_W-1:0]  out_c;
        logic               ack_drive;
        logic               busy_res;
    } result_t;

    typedef struct packed {
        logic               active;
        logic               expected;
        logic [COUNT_W-1:0] byte_count;
        logic [INDEX_W-1:0] target_length;
    } status_t;

endpackage

### rtl/alternating_bit_packet_receiver.sv
// top level of the alternating-bit packet receiver: input register, result register
// depends on abpr_pkg, abpr_check, abpr_ctrl
//
// each request on the s_ side is one poll carrying a six-byte packet; every
// request produces exactly one result on the m_ side, in order
// a packet is taken into the input register, classified and applied to the
// transfer state on its way into the result register
// a request passes through the input register and then the result register
// before its result is offered on the m_ side
// throughput: one request per cycle while m_tready is high, set by one pass
// from input register through check and state logic into the result register
// s_tready stays high while the input register is empty or will move on in
// the same cycle; a stalled m_ side fills both registers and then holds
// s_tready low until m_tready returns
// reset: no transfer active, ack bit low, byte count zero, length 50, and
// both registers empty
// ack_drive in the result follows the ack bit
module alternating_bit_packet_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // control_byte, payload_a, payload_b, payload_c, check_high, check_low
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // accepted, write_index, out_a, out_b, out_c, ack_drive, busy_res, zero fill
    output logic [47:0] m_tdata,
    // packet_kind
    output logic [1:0]  m_tuser
);

    logic                   in_valid_reg;
    abpr_pkg::packet_t      in_pkt_reg;
    logic                   out_valid_reg;
    abpr_pkg::result_t      out_res_reg;
    logic                   advance;
    abpr_pkg::packet_kind_t kind;
    abpr_pkg::result_t      res;
    abpr_pkg::status_t      status;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_pkt_reg <= abpr_pkg::packet_t'(s_tdata);
        end
    end

    abpr_check u_check
    (
        .pkt  (in_pkt_reg),
        .kind (kind)
    );

    abpr_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .pkt    (in_pkt_reg),
        .kind   (kind),
        .res    (res),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.packet_kind;
    assign m_tdata  = {5'd0,
                       out_res_reg.busy_res,
                       out_res_reg.ack_drive,
                       out_res_reg.out_c,
                       out_res_reg.out_b,
                       out_res_reg.out_a,
                       out_res_reg.write_index,
                       out_res_reg.accepted};

    // taken bytes only come from a valid data packet
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tuser == abpr_pkg::KIND_DATA)
        else $error("accepted result without a data packet");

    // a poll with nothing taken reports zero index and bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[40:1] == '0)
        else $error("nonzero payload on a result with nothing taken");

    // every taken packet flips the ack bit
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.accepted |=> status.expected != $past(status.expected))
        else $error("ack bit did not toggle after a taken packet");

    // while a transfer runs the count never passes the length by more than two
    assert property (@(posedge clk) disable iff (!rst_n)
        status.active |->
            status.byte_count <= ({1'b0, status.target_length} + abpr_pkg::COUNT_W'(2)))
        else $error("byte count overran the target length");

    // the ack bit reported follows the state once the result is registered
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_res_reg.ack_drive == status.expected
                    && out_res_reg.busy_res == status.active)
        else $error("result status out of step with the transfer state");

endmodule

### rtl/abpr_check.sv
// check word validation and packet classification
// depends on abpr_pkg
module abpr_check
(
    input  abpr_pkg::packet_t      pkt,
    output abpr_pkg::packet_kind_t kind
);

    logic [abpr_pkg::BYTE_W-1:0] parity;
    logic                        check_ok;

    assign parity   = pkt.control_byte ^ pkt.payload_a ^ pkt.payload_b ^ pkt.payload_c;
    assign check_ok = (pkt.check_high == parity) && (pkt.check_low == ~parity);

    always_comb
    begin
        if (!check_ok)
        begin
            kind = abpr_pkg::KIND_INVALID;
        end
        else if (pkt.control_byte[abpr_pkg::TYPE_BIT])
        begin
            kind = abpr_pkg::KIND_DATA;
        end
        else
        begin
            kind = abpr_pkg::KIND_META;
        end
    end

endmodule

### rtl/abpr_ctrl.sv
// transfer state, ack bit and byte count, and the result of one request
// depends on abpr_pkg
module abpr_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  abpr_pkg::packet_t      pkt,
    input  abpr_pkg::packet_kind_t kind,
    output abpr_pkg::result_t      res,
    output abpr_pkg::status_t      status
);

    logic                                 active_reg;
    logic                                 active_next;
    logic                                 expected_reg;
    logic                                 expected_next;
    logic [abpr_pkg::COUNT_W-1:0]         count_reg;
    logic [abpr_pkg::COUNT_W-1:0]         count_next;
    logic [abpr_pkg::INDEX_W-1:0]         length_reg;
    logic [abpr_pkg::INDEX_W-1:0]         length_next;
    logic                                 took;

    assign took = active_reg && (kind == abpr_pkg::KIND_DATA)
                  && (pkt.control_byte[abpr_pkg::SEQ_BIT] == expected_reg);

    always_comb
    begin
        active_next   = active_reg;
        expected_next = expected_reg;
        count_next    = count_reg;
        length_next   = length_reg;
        if (!active_reg)
        begin
            if (kind == abpr_pkg::KIND_META)
            begin
                length_next   = {pkt.payload_a, pkt.payload_b};
                count_next    = '0;
                active_next   = 1'b1;
                expected_next = 1'b1;
            end
        end
        else
        begin
            if (took)
            begin
                count_next    = count_reg + abpr_pkg::COUNT_STEP;
                expected_next = ~expected_reg;
            end
            if (count_next >= {1'b0, length_reg})
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        res.packet_kind = kind;
        res.accepted    = took;
        res.write_index = took ? count_reg[abpr_pkg::INDEX_W-1:0] : '0;
        res.out_a       = took ? pkt.payload_a : '0;
        res.out_b       = took ? pkt.payload_b : '0;
        res.out_c       = took ? pkt.payload_c : '0;
        res.ack_drive   = expected_next;
        res.busy_res    = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            expected_reg <= 1'b0;
            count_reg    <= '0;
            length_reg   <= abpr_pkg::RESET_LENGTH;
        end
        else if (step)
        begin
            active_reg   <= active_next;
            expected_reg <= expected_next;
            count_reg    <= count_next;
            length_reg   <= length_next;
        end
    end

    assign status.active        = active_reg;
    assign status.expected      = expected_reg;
    assign status.byte_count    = count_reg;
    assign status.target_length = length_reg;

endmodule
